>>> design/plane_grid_vertex_generator_assert.svh
// Assertion macros for the plane grid vertex generator modules.
// No dependencies; included by the files that carry assertions.
`ifndef PLANE_GRID_VERTEX_GENERATOR_ASSERT_SVH
`define PLANE_GRID_VERTEX_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PGVG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PGVG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PGVG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PGVG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/pgvg_pkg.sv
// Package of the plane grid vertex generator: widths, register indexes, state type.
// No dependencies.
package pgvg_pkg;
    localparam int MAX_SUBDIV_DEFAULT = 256;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 64;
    localparam int LEN_W = 16;
    localparam int GRID_W = 9;
    localparam int BASE_W = 24;
    localparam int FRAME_W = 64;
    localparam int COEF_W = 16;
    localparam int POS_W = 32;
    localparam int TEX_W = 17;
    localparam int IDX_W = 25;
    localparam int LOC_W = 25;
    localparam int PROD_W = COEF_W + LOC_W;
    localparam int ACC_W = 44;
    localparam int FIFO_DEPTH = 2;

    localparam logic [CFG_AW-1:0] REG_LENGTH_X = 3'd0;
    localparam logic [CFG_AW-1:0] REG_LENGTH_Y = 3'd1;
    localparam logic [CFG_AW-1:0] REG_COLUMNS = 3'd2;
    localparam logic [CFG_AW-1:0] REG_ROWS = 3'd3;
    localparam logic [CFG_AW-1:0] REG_BASE_INDEX = 3'd4;
    localparam logic [CFG_AW-1:0] REG_FRAME_X = 3'd5;
    localparam logic [CFG_AW-1:0] REG_FRAME_Y = 3'd6;
    localparam logic [CFG_AW-1:0] REG_FRAME_Z = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LAUNCH = 5'b00010,
        S_DIV = 5'b00100,
        S_MUL = 5'b01000,
        S_OUT = 5'b10000
    } t_back_state;
endpackage

>>> design/pgvg_front.sv
// Front part: accepts input beats, resolves the vertex address and quad flags.
// Depends on pgvg_pkg.
module pgvg_front #(
    parameter int MAX_SUB = pgvg_pkg::MAX_SUBDIV_DEFAULT,
    parameter int CW = $clog2(MAX_SUB),
    parameter int SW = $clog2(MAX_SUB + 1),
    parameter int IW = 2 * CW + 2 + pgvg_pkg::IDX_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_restart,
    input  logic [SW-1:0]                i_nc,
    input  logic [SW-1:0]                i_nr,
    input  logic [pgvg_pkg::BASE_W-1:0]  i_base,
    input  logic                         i_full,
    output logic                         o_push,
    output logic [IW-1:0]                o_item
);
    import pgvg_pkg::*;

    logic [CW-1:0] r_c, r_r, n_c, n_r;
    logic          wrap, quad, last;
    logic [CW-1:0] c_use, r_use;
    logic [SW-1:0] c1, r1;
    logic [IDX_W-1:0] tl;

    assign o_in_stall = i_full;
    assign o_push = i_in_valid && !i_full;

    always_comb begin
        wrap = i_restart || (SW'(r_c) >= i_nc) || (SW'(r_r) >= i_nr);
        c_use = wrap ? '0 : r_c;
        r_use = wrap ? '0 : r_r;
        c1 = SW'(c_use) + SW'(1);
        r1 = SW'(r_use) + SW'(1);
        quad = (c1 < i_nc) && (r1 < i_nr);
        last = (c1 == i_nc) && (r1 == i_nr);
        tl = IDX_W'(i_base) + IDX_W'(r_use) * IDX_W'(i_nc) + IDX_W'(c_use);
        if (c1 < i_nc) begin
            n_c = CW'(c1);
            n_r = r_use;
        end else begin
            n_c = '0;
            n_r = (r1 < i_nr) ? CW'(r1) : '0;
        end
    end

    assign o_item = {c_use, r_use, quad, last, tl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
            r_r <= '0;
        end else if (o_push) begin
            r_c <= n_c;
            r_r <= n_r;
        end
    end
endmodule

>>> design/pgvg_fifo.sv
// Short queue between the front and back parts.
// Depends on pgvg_pkg and the assertion macro header.
`include "plane_grid_vertex_generator_assert.svh"
module pgvg_fifo #(
    parameter int W = 1,
    parameter int DEPTH = pgvg_pkg::FIFO_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;

    assign o_full = (r_cnt == NW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    `PGVG_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= NW'(DEPTH))
    `PGVG_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_pop, o_valid)
    `PGVG_ASSERT_NXT(a_push_grows, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + NW'(1))
endmodule

>>> design/pgvg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pgvg_pkg only through its users.
module pgvg_div #(
    parameter int NW = 33,
    parameter int DW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] r_num, r_quo;
    logic [DW-1:0] r_rem, r_den;
    logic [KW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [DW:0]   trial;
    logic          ge;

    assign trial = {r_rem, r_num[NW-1]};
    assign ge = trial >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quo = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= ge ? DW'(trial - {1'b0, r_den}) : DW'(trial);
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= KW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - KW'(1);
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

>>> design/pgvg_back.sv
// Back part: local coordinates, texture fractions, frame transform, output register.
// Depends on pgvg_pkg and pgvg_div.
module pgvg_back #(
    parameter int MAX_SUB = pgvg_pkg::MAX_SUBDIV_DEFAULT,
    parameter int CW = $clog2(MAX_SUB),
    parameter int SW = $clog2(MAX_SUB + 1),
    parameter int IW = 2 * CW + 2 + pgvg_pkg::IDX_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  logic [IW-1:0]                 i_item,
    output logic                          o_pop,
    input  logic [SW-1:0]                 i_nc,
    input  logic [SW-1:0]                 i_nr,
    input  logic [pgvg_pkg::LEN_W-1:0]    i_len_x,
    input  logic [pgvg_pkg::LEN_W-1:0]    i_len_y,
    input  logic [pgvg_pkg::FRAME_W-1:0]  i_frame_x,
    input  logic [pgvg_pkg::FRAME_W-1:0]  i_frame_y,
    input  logic [pgvg_pkg::FRAME_W-1:0]  i_frame_z,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pgvg_pkg::POS_W-1:0]    o_pos_x,
    output logic [pgvg_pkg::POS_W-1:0]    o_pos_y,
    output logic [pgvg_pkg::POS_W-1:0]    o_pos_z,
    output logic [pgvg_pkg::TEX_W-1:0]    o_tex_u,
    output logic [pgvg_pkg::TEX_W-1:0]    o_tex_v,
    output logic                          o_quad_valid,
    output logic [pgvg_pkg::IDX_W-1:0]    o_corner_top_left,
    output logic [pgvg_pkg::IDX_W-1:0]    o_corner_top_right,
    output logic [pgvg_pkg::IDX_W-1:0]    o_corner_bottom_left,
    output logic [pgvg_pkg::IDX_W-1:0]    o_corner_bottom_right,
    output logic                          o_last_vertex
);
    import pgvg_pkg::*;

    localparam int NW = 25 + CW;
    localparam int DW = CW + 1;

    function automatic logic [POS_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-9:0] rr;
        logic [POS_W-1:0] res;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        rr = (ACC_W - 8)'((mag + ACC_W'(128)) >> 8);
        if (!v[ACC_W-1]) begin
            res = (rr > (ACC_W - 8)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : POS_W'(rr);
        end else begin
            res = (rr > (ACC_W - 8)'(32'h8000_0000)) ? 32'h8000_0000 : POS_W'(-rr);
        end
        return res;
    endfunction

    t_back_state r_state;
    logic [CW-1:0]    r_c, r_r;
    logic             r_quad, r_last, r_neg;
    logic [IDX_W-1:0] r_tl;
    logic [1:0]       r_job, r_axis, r_ph;
    logic signed [LOC_W-1:0]  r_x, r_y;
    logic [TEX_W-1:0]         r_u, r_v;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [POS_W-1:0]         r_pos [3];
    logic [IDX_W-1:0] r_c_tl, r_c_tr, r_c_bl, r_c_br;

    logic [CW-1:0]    k;
    logic [SW-1:0]    n;
    logic [LEN_W-1:0] len;
    logic signed [SW+1:0] d;
    logic [SW:0]      ad;
    logic [NW-1:0]    num;
    logic [DW-1:0]    den;
    logic             div_start, div_done;
    logic [NW-1:0]    quo;
    logic [LOC_W-1:0] qloc;
    logic [FRAME_W-1:0] frame;
    logic signed [COEF_W-1:0] bx, by, org;

    always_comb begin
        k = r_job[0] ? r_r : r_c;
        n = r_job[0] ? (i_nr - SW'(1)) : (i_nc - SW'(1));
        len = r_job[0] ? i_len_y : i_len_x;
        d = (SW + 2)'({k, 1'b0}) - (SW + 2)'(n);
        ad = d[SW+1] ? (SW + 1)'(-d) : (SW + 1)'(d);
        if (r_job[1]) begin
            num = (NW'(k) << 17) + NW'(n);
        end else begin
            num = ((NW'(len) * NW'(ad)) << 8) + NW'(n);
        end
        den = DW'({n, 1'b0});
    end

    assign div_start = (r_state == S_LAUNCH);

    pgvg_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign qloc = r_neg ? LOC_W'(-quo[LOC_W-1:0]) : quo[LOC_W-1:0];

    always_comb begin
        case (r_axis)
            2'd0: frame = i_frame_x;
            2'd1: frame = i_frame_y;
            default: frame = i_frame_z;
        endcase
        bx = frame[15:0];
        by = frame[31:16];
        org = frame[63:48];
    end

    assign o_pop = (r_state == S_IDLE) && i_item_valid;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            {r_c, r_r, r_quad, r_last, r_tl} <= i_item;
        end
        if (div_start) begin
            r_neg <= d[SW+1];
        end
        if (r_state == S_DIV && div_done) begin
            case (r_job)
                2'd0: r_x <= qloc;
                2'd1: r_y <= qloc;
                2'd2: r_u <= TEX_W'(quo);
                default: r_v <= TEX_W'(quo);
            endcase
        end
        if (r_state == S_MUL) begin
            case (r_ph)
                2'd0: begin
                    r_prod <= bx * r_x;
                    r_acc <= ACC_W'(org) <<< 16;
                end
                2'd1: begin
                    r_prod <= by * r_y;
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
                2'd2: r_acc <= r_acc + ACC_W'(r_prod);
                default: r_pos[r_axis] <= round_sat(r_acc);
            endcase
            if (r_ph == 2'd3 && r_axis == 2'd2) begin
                r_c_tl <= r_quad ? r_tl : '0;
                r_c_tr <= r_quad ? r_tl + IDX_W'(1) : '0;
                r_c_bl <= r_quad ? r_tl + IDX_W'(i_nc) : '0;
                r_c_br <= r_quad ? r_tl + IDX_W'(i_nc) + IDX_W'(1) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job <= '0;
            r_axis <= '0;
            r_ph <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_job <= '0;
                        r_state <= S_LAUNCH;
                    end
                end
                S_LAUNCH: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        if (r_job == 2'd3) begin
                            r_axis <= '0;
                            r_ph <= '0;
                            r_state <= S_MUL;
                        end else begin
                            r_job <= r_job + 2'd1;
                            r_state <= S_LAUNCH;
                        end
                    end
                end
                S_MUL: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == 2'd3) begin
                        if (r_axis == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_axis <= r_axis + 2'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_pos_x = r_pos[0];
    assign o_pos_y = r_pos[1];
    assign o_pos_z = r_pos[2];
    assign o_tex_u = r_u;
    assign o_tex_v = r_v;
    assign o_quad_valid = r_quad;
    assign o_last_vertex = r_last;
    assign o_corner_top_left = r_c_tl;
    assign o_corner_top_right = r_c_tr;
    assign o_corner_bottom_left = r_c_bl;
    assign o_corner_bottom_right = r_c_br;
endmodule

>>> design/plane_grid_vertex_generator.sv
// Top level of the plane grid vertex generator: configuration registers and wiring.
// Depends on pgvg_pkg, pgvg_front, pgvg_fifo and pgvg_back.
//
//   channel  | handshake                    | payload
//   input    | i_in_valid / o_in_stall      | i_restart
//   output   | o_out_valid / i_out_stall    | o_pos_*, o_tex_*, o_quad_valid, o_corner_*, o_last_vertex
//   config   | i_cfg_we                     | i_cfg_addr, i_cfg_data
//
// The back part works on one vertex at a time, with NW = 25 + log2(MAX_SUBDIV) quotient bits per division;
// its four divisions share the bit-serial divider, and it takes a new vertex only after the last is sent.
// The front part takes a beat whenever the two-entry queue has room.
// Reset is synchronous and active low and restores the register defaults and vertex 0.
// A stalled output holds its beat while the front part keeps taking input beats until the queue is full.
module plane_grid_vertex_generator #(
    parameter int MAX_SUBDIV = pgvg_pkg::MAX_SUBDIV_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pgvg_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [pgvg_pkg::CFG_DW-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pgvg_pkg::POS_W-1:0]    o_pos_x,
    output logic [pgvg_pkg::POS_W-1:0]    o_pos_y,
    output logic [pgvg_pkg::POS_W-1:0]    o_pos_z,
    output logic [pgvg_pkg::TEX_W-1:0]    o_tex_u,
    output logic [pgvg_pkg::TEX_W-1:0]    o_tex_v,
    output logic                          o_quad_valid,
    output logic [pgvg_pkg::IDX_W-1:0]    o_corner_top_left,
    output logic [pgvg_pkg::IDX_W-1:0]    o_corner_top_right,
    output logic [pgvg_pkg::IDX_W-1:0]    o_corner_bottom_left,
    output logic [pgvg_pkg::IDX_W-1:0]    o_corner_bottom_right,
    output logic                          o_last_vertex
);
    import pgvg_pkg::*;

    localparam int CW = $clog2(MAX_SUBDIV);
    localparam int SW = $clog2(MAX_SUBDIV + 1);
    localparam int IW = 2 * CW + 2 + IDX_W;

    logic [LEN_W-1:0]   r_len_x, r_len_y;
    logic [GRID_W-1:0]  r_cols, r_rows;
    logic [BASE_W-1:0]  r_base;
    logic [FRAME_W-1:0] r_fx, r_fy, r_fz;
    logic [SW-1:0]      nc, nr;
    logic               push, full, pop, qvalid;
    logic [IW-1:0]      item_in, item_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_x <= LEN_W'(256);
            r_len_y <= LEN_W'(256);
            r_cols <= GRID_W'(2);
            r_rows <= GRID_W'(2);
            r_base <= '0;
            r_fx <= FRAME_W'(64'h0000_0000_0000_0100);
            r_fy <= FRAME_W'(64'h0000_0000_0100_0000);
            r_fz <= FRAME_W'(64'h0000_0100_0000_0000);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LENGTH_X: r_len_x <= i_cfg_data[LEN_W-1:0];
                REG_LENGTH_Y: r_len_y <= i_cfg_data[LEN_W-1:0];
                REG_COLUMNS: r_cols <= i_cfg_data[GRID_W-1:0];
                REG_ROWS: r_rows <= i_cfg_data[GRID_W-1:0];
                REG_BASE_INDEX: r_base <= i_cfg_data[BASE_W-1:0];
                REG_FRAME_X: r_fx <= i_cfg_data;
                REG_FRAME_Y: r_fy <= i_cfg_data;
                REG_FRAME_Z: r_fz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cols < GRID_W'(2)) begin
            nc = SW'(2);
        end else if (32'(r_cols) > MAX_SUBDIV) begin
            nc = SW'(MAX_SUBDIV);
        end else begin
            nc = SW'(r_cols);
        end
        if (r_rows < GRID_W'(2)) begin
            nr = SW'(2);
        end else if (32'(r_rows) > MAX_SUBDIV) begin
            nr = SW'(MAX_SUBDIV);
        end else begin
            nr = SW'(r_rows);
        end
    end

    pgvg_front #(.MAX_SUB(MAX_SUBDIV)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_restart  (i_restart),
        .i_nc       (nc),
        .i_nr       (nr),
        .i_base     (r_base),
        .i_full     (full),
        .o_push     (push),
        .o_item     (item_in)
    );

    pgvg_fifo #(.W(IW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (item_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (qvalid),
        .o_data  (item_out)
    );

    pgvg_back #(.MAX_SUB(MAX_SUBDIV)) u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_item_valid          (qvalid),
        .i_item                (item_out),
        .o_pop                 (pop),
        .i_nc                  (nc),
        .i_nr                  (nr),
        .i_len_x               (r_len_x),
        .i_len_y               (r_len_y),
        .i_frame_x             (r_fx),
        .i_frame_y             (r_fy),
        .i_frame_z             (r_fz),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_pos_x               (o_pos_x),
        .o_pos_y               (o_pos_y),
        .o_pos_z               (o_pos_z),
        .o_tex_u               (o_tex_u),
        .o_tex_v               (o_tex_v),
        .o_quad_valid          (o_quad_valid),
        .o_corner_top_left     (o_corner_top_left),
        .o_corner_top_right    (o_corner_top_right),
        .o_corner_bottom_left  (o_corner_bottom_left),
        .o_corner_bottom_right (o_corner_bottom_right),
        .o_last_vertex         (o_last_vertex)
    );
endmodule
